/* rtl/core/fbrs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the free bitmap run statistics block.
// No dependencies; every other file in rtl/core refers to this package.
package fbrs_pkg;

  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned RUN_W        = 6;       // holds 0..WORD_BITS
  localparam int unsigned CNT_W        = 17;      // granule count and result width
  localparam int unsigned CNT_LIMIT    = 131071;  // largest count the register can hold
  localparam int unsigned MAX_GRANULES = 65536;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam logic [CNT_W-1:0] GRANULE_COUNT_RST = 17'd65536;

  // One classified bitmap word: granules past the end already read as allocated
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 last;
  } q_entry_t;

  // Per-word free-granule statistics
  typedef struct packed {
    logic [RUN_W-1:0] free_cnt;
    logic [RUN_W-1:0] low_run;
    logic [RUN_W-1:0] high_run;
    logic [RUN_W-1:0] long_run;
    logic             all_free;
  } word_stats_t;

endpackage

/* rtl/core/free_bitmap_run_statistics.sv */
`timescale 1ns / 1ps
// Free bitmap run statistics: 32-bit bitmap words in, one result per scan.
// Final word path to out_valid: queue, statistics register, result register.
// Throughput: one word per cycle while the queue has room; the result register lets
// the next scan proceed while a result waits.
// Reset (rst_n, synchronous): scan state and queue cleared, granule_count = 65536.
// Depends on fbrs_pkg, fbrs_front, fbrs_queue, fbrs_back.
module free_bitmap_run_statistics #(
  parameter int unsigned MAX_GRANULES = fbrs_pkg::MAX_GRANULES,
  parameter int unsigned QUEUE_DEPTH  = fbrs_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [fbrs_pkg::CNT_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fbrs_pkg::WORD_BITS-1:0] in_map_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fbrs_pkg::CNT_W-1:0]     out_free_total,
  output logic [fbrs_pkg::CNT_W-1:0]     out_longest_free_run
);

  fbrs_pkg::q_entry_t push_entry, head;
  logic               push, pop, not_full, not_empty;

  // Front: hold the count, classify each word and mask past the last granule
  fbrs_front #(
    .MAX_GRANULES (MAX_GRANULES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_map_word (in_map_word),
    .q_ready     (not_full),
    .q_push      (push),
    .q_entry     (push_entry)
  );

  // Queue: decouple classification from merging so each side stalls alone
  fbrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (not_full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  // Back: per-word statistics, merge runs across word boundaries, drive the result
  fbrs_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (not_empty),
    .q_head               (head),
    .q_pop                (pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_free_total       (out_free_total),
    .out_longest_free_run (out_longest_free_run)
  );

endmodule

/* rtl/core/fbrs_front.sv */
`timescale 1ns / 1ps
// Front end: holds the granule count, tracks the word position, masks the
// final word and flags it. Depends on fbrs_pkg.
module fbrs_front #(
  parameter int unsigned MAX_GRANULES = fbrs_pkg::MAX_GRANULES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [fbrs_pkg::CNT_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fbrs_pkg::WORD_BITS-1:0] in_map_word,
  input  logic                           q_ready,
  output logic                           q_push,
  output fbrs_pkg::q_entry_t             q_entry
);

  localparam int unsigned EFF_MAX   = (MAX_GRANULES < fbrs_pkg::CNT_LIMIT) ?
                                      MAX_GRANULES : fbrs_pkg::CNT_LIMIT;
  localparam int unsigned WORDS_MAX = (EFF_MAX + fbrs_pkg::WORD_BITS - 1) /
                                      fbrs_pkg::WORD_BITS;
  localparam int unsigned POS_W     = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1;
  localparam int unsigned SH_W      = $clog2(fbrs_pkg::WORD_BITS);
  localparam int unsigned BASE_W    = POS_W + SH_W;
  localparam int unsigned CMP_W     = ((BASE_W > fbrs_pkg::CNT_W) ?
                                       BASE_W : fbrs_pkg::CNT_W) + 1;
  localparam logic [fbrs_pkg::CNT_W-1:0] CAP = fbrs_pkg::CNT_W'(EFF_MAX);

  logic [fbrs_pkg::CNT_W-1:0] granule_count_r;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [fbrs_pkg::CNT_W-1:0] eff_count;
  logic [CMP_W-1:0]           base_ext, eff_ext, remain;
  logic [fbrs_pkg::RUN_W-1:0] nbits;
  logic                       last;
  logic [fbrs_pkg::WORD_BITS:0]   lo_mask;
  logic [fbrs_pkg::WORD_BITS-1:0] valid_mask;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  // Clamp the count to what the bitmap can hold
  assign eff_count = (granule_count_r > CAP) ? CAP : granule_count_r;
  assign base_ext  = CMP_W'({pos_r, SH_W'(0)});
  assign eff_ext   = CMP_W'(eff_count);
  assign remain    = eff_ext - base_ext;

  always_comb begin
    priority if (base_ext >= eff_ext) begin
      nbits = '0;
      last  = 1'b1;
    end else if (remain <= CMP_W'(fbrs_pkg::WORD_BITS)) begin
      nbits = remain[fbrs_pkg::RUN_W-1:0];
      last  = 1'b1;
    end else begin
      nbits = fbrs_pkg::RUN_W'(fbrs_pkg::WORD_BITS);
      last  = 1'b0;
    end
  end

  // Granules at or past the end read as allocated
  assign lo_mask    = ((fbrs_pkg::WORD_BITS+1)'(1) << nbits) - (fbrs_pkg::WORD_BITS+1)'(1);
  assign valid_mask = lo_mask[fbrs_pkg::WORD_BITS-1:0];

  assign q_entry.word = in_map_word | ~valid_mask;
  assign q_entry.last = last;

  assign pos_nxt = last ? '0 : pos_r + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      granule_count_r <= fbrs_pkg::GRANULE_COUNT_RST;
      pos_r           <= '0;
    end else begin
      if (cfg_wr_en) begin
        granule_count_r <= cfg_wr_data;
      end
      if (q_push) begin
        pos_r <= pos_nxt;
      end
    end
  end

endmodule

/* rtl/core/fbrs_queue.sv */
`timescale 1ns / 1ps
// Short queue of classified words between front and back end.
// Depends on fbrs_pkg.
module fbrs_queue #(
  parameter int unsigned DEPTH = fbrs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fbrs_pkg::q_entry_t push_entry,
  output logic               not_full,
  input  logic               pop,
  output logic               not_empty,
  output fbrs_pkg::q_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fbrs_pkg::q_entry_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue holds more items than its depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue popped while empty");

endmodule

/* rtl/core/fbrs_wstat.sv */
`timescale 1ns / 1ps
// Per-word statistics: free count, low and high free runs, longest free run, all-free flag.
// Depends on fbrs_pkg.
module fbrs_wstat (
  input  logic [fbrs_pkg::WORD_BITS-1:0] word,
  output fbrs_pkg::word_stats_t          stats
);

  localparam int unsigned W = fbrs_pkg::WORD_BITS;
  localparam int unsigned R = fbrs_pkg::RUN_W;

  logic [W-1:0] z;
  logic [W-1:0] r1, r2, r4, r8, r16;
  logic [R-1:0] free_cnt, low_run, high_run, long_run;

  assign z   = ~word;
  // Bit p of rK: a free run of at least K granules starts at p
  assign r1  = z;
  assign r2  = r1 & (r1 >> 1);
  assign r4  = r2 & (r2 >> 2);
  assign r8  = r4 & (r4 >> 4);
  assign r16 = r8 & (r8 >> 8);

  always_comb begin
    free_cnt = '0;
    for (int i = 0; i < W; i++) begin
      free_cnt = free_cnt + R'(z[i]);
    end
  end

  always_comb begin
    low_run = R'(W);
    for (int i = W - 1; i >= 0; i--) begin
      if (word[i]) low_run = R'(i);
    end
  end

  always_comb begin
    high_run = R'(W);
    for (int i = 0; i < W; i++) begin
      if (word[i]) high_run = R'(W - 1 - i);
    end
  end

  // Build the longest run greedily, one power of two at a time; ends tracks
  // where runs of the length found so far end
  always_comb begin
    logic [W-1:0] ends;
    logic [W-1:0] hit;
    ends     = '1;
    long_run = '0;
    hit = ends & r16;
    if (hit != '0) begin ends = hit << 16; long_run = long_run + R'(16); end
    hit = ends & r8;
    if (hit != '0) begin ends = hit << 8;  long_run = long_run + R'(8);  end
    hit = ends & r4;
    if (hit != '0) begin ends = hit << 4;  long_run = long_run + R'(4);  end
    hit = ends & r2;
    if (hit != '0) begin ends = hit << 2;  long_run = long_run + R'(2);  end
    hit = ends & r1;
    if (hit != '0) begin long_run = long_run + R'(1); end
    if (word == '0) long_run = R'(W);
  end

  assign stats.free_cnt = free_cnt;
  assign stats.low_run  = low_run;
  assign stats.high_run = high_run;
  assign stats.long_run = long_run;
  assign stats.all_free = (word == '0);

endmodule

/* rtl/core/fbrs_back.sv */
`timescale 1ns / 1ps
// Back end: word statistics stage, run merge and result register.
// Depends on fbrs_pkg and fbrs_wstat.
module fbrs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  fbrs_pkg::q_entry_t         q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fbrs_pkg::CNT_W-1:0] out_free_total,
  output logic [fbrs_pkg::CNT_W-1:0] out_longest_free_run
);

  localparam int unsigned C = fbrs_pkg::CNT_W;

  fbrs_pkg::word_stats_t st_in, st_r;
  logic                  st_valid_r, st_last_r;
  logic                  consume;
  logic [C-1:0] free_sum_r, free_sum_nxt;
  logic [C-1:0] open_r, open_nxt;
  logic [C-1:0] best_r, best_nxt;
  logic [C-1:0] cand, m_a, m_b, lh_max, final_run;
  logic         out_valid_r;
  logic [C-1:0] out_free_total_r, out_longest_r;

  fbrs_wstat u_wstat (
    .word  (q_head.word),
    .stats (st_in)
  );

  // A final word waits only while the result register is still full
  assign consume = st_valid_r && !(st_last_r && out_valid_r && !out_ready);
  assign q_pop   = q_valid && (!st_valid_r || consume);

  assign cand   = open_r + C'(st_r.low_run);
  assign m_a    = (cand > best_r) ? cand : best_r;
  assign lh_max = (st_r.long_run > st_r.high_run) ? C'(st_r.long_run) : C'(st_r.high_run);
  assign m_b    = st_r.all_free ? '0 : lh_max;

  assign free_sum_nxt = free_sum_r + C'(st_r.free_cnt);
  assign open_nxt     = st_r.all_free ? cand : C'(st_r.high_run);
  assign best_nxt     = st_r.all_free ? best_r :
                        ((C'(st_r.long_run) > m_a) ? C'(st_r.long_run) : m_a);
  assign final_run    = (m_b > m_a) ? m_b : m_a;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      st_r      <= st_in;
      st_last_r <= q_head.last;
    end
    if (consume && st_last_r) begin
      out_free_total_r <= free_sum_nxt;
      out_longest_r    <= final_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r  <= 1'b0;
      free_sum_r  <= '0;
      open_r      <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        st_valid_r <= 1'b1;
      end else if (consume) begin
        st_valid_r <= 1'b0;
      end
      if (consume) begin
        if (st_last_r) begin
          free_sum_r <= '0;
          open_r     <= '0;
          best_r     <= '0;
        end else begin
          free_sum_r <= free_sum_nxt;
          open_r     <= open_nxt;
          best_r     <= best_nxt;
        end
      end
      if (consume && st_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_free_total       = out_free_total_r;
  assign out_longest_free_run = out_longest_r;

  a_run_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_longest_r <= out_free_total_r))
    else $error("longest free run exceeds free total");

  a_scan_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && st_last_r) |=> (free_sum_r == '0 && open_r == '0 && best_r == '0))
    else $error("scan state not cleared after final word");

endmodule
